### src/hidkm_pkg.sv
// ----------------------------------------------------------------------------
// hidkm_pkg
// Shared types and constants of the HID keyboard/mouse frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hidkm_pkg;

   // Key slots held by the keyboard report (1..6)
   localparam int KEY_SLOTS = 6;
   // Report bytes always carry six slot positions
   localparam int REPORT_SLOTS = 6;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_DEVICE_ADDRESS = 1'b0;   // paddr[2]

   // Event codes
   typedef enum logic [2:0] {
      OP_KEY_PRESS   = 3'd0,
      OP_KEY_RELEASE = 3'd1,
      OP_BTN_PRESS   = 3'd2,
      OP_BTN_RELEASE = 3'd3,
      OP_MOVE        = 3'd4,
      OP_WHEEL       = 3'd5
   } op_type;

   // Frame constants
   localparam logic [7:0] HEAD0        = 8'h57;
   localparam logic [7:0] HEAD1        = 8'hAB;
   localparam logic [7:0] CMD_KEYBOARD = 8'h02;
   localparam logic [7:0] LEN_KEYBOARD = 8'h08;
   localparam logic [7:0] CMD_MOUSE    = 8'h05;
   localparam logic [7:0] LEN_MOUSE    = 8'h05;
   localparam logic [7:0] MOUSE_ID     = 8'h01;
   localparam logic [4:0] MOD_PREFIX   = 5'b11100;   // E0..E7
   localparam logic [7:0] DELTA_MIN    = 8'h80;
   localparam int         NUM_BUTTONS  = 3;

   // Byte positions inside a frame
   localparam logic [3:0] POS_HEAD0  = 4'd0;
   localparam logic [3:0] POS_HEAD1  = 4'd1;
   localparam logic [3:0] POS_ADDR   = 4'd2;
   localparam logic [3:0] POS_CMD    = 4'd3;
   localparam logic [3:0] POS_LEN    = 4'd4;
   localparam logic [3:0] POS_DATA0  = 4'd5;
   localparam logic [3:0] POS_DATA1  = 4'd6;
   localparam logic [3:0] POS_DATA2  = 4'd7;
   localparam logic [3:0] POS_DATA3  = 4'd8;
   localparam logic [3:0] POS_DATA4  = 4'd9;
   localparam logic [3:0] POS_KB_SUM = 4'd13;
   localparam logic [3:0] POS_MS_SUM = 4'd10;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   // -128 has no symmetric counterpart and goes out as zero
   function automatic logic [7:0] delta_byte(input logic [7:0] b);
      delta_byte = (b == DELTA_MIN) ? 8'h00 : b;
   endfunction

endpackage

`default_nettype wire

### src/hidkm_if.sv
// ----------------------------------------------------------------------------
// hidkm_req_if / hidkm_rsp_if
// Valid/ready channels carrying input events and frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hidkm_req_if;
   logic              valid;
   logic              ready;
   logic        [2:0] op;
   logic        [7:0] key_code;
   logic        [7:0] mouse_button;
   logic signed [7:0] delta_x;
   logic signed [7:0] delta_y;
   logic signed [7:0] wheel_delta;

   modport source (output valid, op, key_code, mouse_button, delta_x, delta_y,
                   wheel_delta, input ready);
   modport sink   (input valid, op, key_code, mouse_button, delta_x, delta_y,
                   wheel_delta, output ready);
endinterface

interface hidkm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

### src/hid_keyboard_mouse_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// hid_keyboard_mouse_frame_encoder_core
// Tracks HID keyboard/mouse state and serializes one framed report per event.
//
// Usage:
//  - req_bus: one event per beat (key press/release, button press/release,
//    move, wheel). Taken only while the sequencer is idle.
//  - rsp_bus: the frame, one byte per beat, frame_last high on the checksum.
//    Keyboard frames are 14 beats, mouse frames 11.
//  - csr: APB write of the device address (offset 0), used in every header.
//  - State is updated at the edge the event is taken; the frame shows the
//    state after the update.
//  - Output: bytes leave through one output register, one byte per cycle
//    while the receiver is ready; an 8-bit adder keeps the running checksum.
//  - Op codes 6 and 7 are taken and dropped without a frame.
//  - Receiver stall: the byte register holds, the sequencer waits; a new
//    event is taken while the final byte still sits in the output register.
//  - Reset clears address, modifiers, key slots and buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_mouse_frame_encoder_core (
   input  wire                                 clock,
   input  wire                                 reset,
   hidkm_req_if.sink                           req_bus,
   hidkm_rsp_if.source                         rsp_bus,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [hidkm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [hidkm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hidkm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import hidkm_pkg::*;

   // ---------------- registers ----------------
   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;          // byte position in frame
   logic [7:0] sum_ff, sum_in;          // running checksum
   logic       kbd_ff, kbd_in;          // keyboard frame vs mouse frame
   logic [7:0] dx_ff, dx_in;
   logic [7:0] dy_ff, dy_in;
   logic [7:0] wh_ff, wh_in;

   logic [7:0] addr_ff, addr_in;
   logic [7:0] mod_ff, mod_in;
   logic [7:0] code_ff [KEY_SLOTS];
   logic [7:0] code_in [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] pressed_ff, pressed_in;
   logic [NUM_BUTTONS-1:0] btn_ff, btn_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   // ---------------- handshakes ----------------
   logic req_fire;
   logic csr_wr;
   logic send_fire;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_pready    = 1'b1;
   assign csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register read-back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_DEVICE_ADDRESS) begin
         csr_prdata[7:0] = addr_ff;
      end
   end

   assign addr_in = (csr_wr && csr_paddr[2] == CSR_IDX_DEVICE_ADDRESS) ?
                    csr_pwdata[7:0] : addr_ff;

   // ---------------- event decode / state update ----------------
   // All slot compares run in parallel; the first-free and first-match
   // searches are priority chains over KEY_SLOTS entries.
   always_comb begin
      logic is_mod;
      logic held;
      logic found;
      logic btn_ok;
      mod_in     = mod_ff;
      code_in    = code_ff;
      pressed_in = pressed_ff;
      btn_in     = btn_ff;
      kbd_in     = kbd_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      wh_in      = wh_ff;
      is_mod = (req_bus.key_code[7:3] == MOD_PREFIX);
      btn_ok = (req_bus.mouse_button < 8'(NUM_BUTTONS));
      held   = 1'b0;
      found  = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (pressed_ff[i] && code_ff[i] == req_bus.key_code) begin
            held = 1'b1;
         end
      end
      if (req_fire) begin
         dx_in = 8'h00;
         dy_in = 8'h00;
         wh_in = 8'h00;
         case (req_bus.op)
            OP_KEY_PRESS: begin
               kbd_in = 1'b1;
               if (is_mod) begin
                  mod_in[req_bus.key_code[2:0]] = 1'b1;
               end else if (!held) begin
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (!found && !pressed_ff[i]) begin
                        found         = 1'b1;
                        pressed_in[i] = 1'b1;
                        code_in[i]    = req_bus.key_code;
                     end
                  end
               end
            end
            OP_KEY_RELEASE: begin
               kbd_in = 1'b1;
               if (is_mod) begin
                  mod_in[req_bus.key_code[2:0]] = 1'b0;
               end else begin
                  // first slot holding the code, pressed or not
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (!found && code_ff[i] == req_bus.key_code) begin
                        found         = 1'b1;
                        pressed_in[i] = 1'b0;
                        code_in[i]    = 8'h00;
                     end
                  end
               end
            end
            OP_BTN_PRESS: begin
               kbd_in = 1'b0;
               if (btn_ok) begin
                  btn_in[req_bus.mouse_button[1:0]] = 1'b1;
               end
            end
            OP_BTN_RELEASE: begin
               kbd_in = 1'b0;
               if (btn_ok) begin
                  btn_in[req_bus.mouse_button[1:0]] = 1'b0;
               end
            end
            OP_MOVE: begin
               kbd_in = 1'b0;
               dx_in  = delta_byte(req_bus.delta_x);
               dy_in  = delta_byte(req_bus.delta_y);
            end
            OP_WHEEL: begin
               kbd_in = 1'b0;
               wh_in  = delta_byte(req_bus.wheel_delta);
            end
            default: begin
               kbd_in = kbd_ff;
            end
         endcase
      end
   end

   // ---------------- frame byte select ----------------
   logic [7:0] cur_byte;
   logic [3:0] last_pos;
   logic       at_last;
   logic [3:0] slot_off;

   assign last_pos = kbd_ff ? POS_KB_SUM : POS_MS_SUM;
   assign at_last  = (idx_ff == last_pos);
   assign slot_off = idx_ff - POS_DATA2;

   always_comb begin
      cur_byte = 8'h00;
      case (idx_ff)
         POS_HEAD0: cur_byte = HEAD0;
         POS_HEAD1: cur_byte = HEAD1;
         POS_ADDR:  cur_byte = addr_ff;
         POS_CMD:   cur_byte = kbd_ff ? CMD_KEYBOARD : CMD_MOUSE;
         POS_LEN:   cur_byte = kbd_ff ? LEN_KEYBOARD : LEN_MOUSE;
         POS_DATA0: cur_byte = kbd_ff ? mod_ff : MOUSE_ID;
         POS_DATA1: cur_byte = kbd_ff ? 8'h00 : {5'b0, btn_ff};
         default: begin
            if (kbd_ff) begin
               // slot bytes; positions past KEY_SLOTS stay zero
               for (int i = 0; i < KEY_SLOTS && i < REPORT_SLOTS; i++) begin
                  if (slot_off == 4'(i) && pressed_ff[i]) begin
                     cur_byte = code_ff[i];
                  end
               end
            end else begin
               case (idx_ff)
                  POS_DATA2: cur_byte = dx_ff;
                  POS_DATA3: cur_byte = dy_ff;
                  POS_DATA4: cur_byte = wh_ff;
                  default:   cur_byte = 8'h00;
               endcase
            end
         end
      endcase
   end

   // ---------------- sequencer ----------------
   assign send_fire = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.op <= OP_WHEEL) begin
               state_in = ST_SEND;
               idx_in   = 4'd0;
               sum_in   = 8'h00;
            end
         end
         ST_SEND: begin
            if (send_fire) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = at_last ? sum_ff : cur_byte;
               rsp_last_in  = at_last;
               sum_in       = sum_ff + cur_byte;
               idx_in       = idx_ff + 4'd1;
               if (at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 4'd0;
         sum_ff       <= 8'h00;
         kbd_ff       <= 1'b0;
         addr_ff      <= 8'h00;
         mod_ff       <= 8'h00;
         pressed_ff   <= '0;
         btn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            code_ff[i] <= 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         kbd_ff       <= kbd_in;
         addr_ff      <= addr_in;
         mod_ff       <= mod_in;
         pressed_ff   <= pressed_in;
         btn_ff       <= btn_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff      <= code_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      wh_ff       <= wh_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.frame_byte = rsp_byte_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule

`default_nettype wire

### tb/sv/hidkm_frame_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hidkm_frame_check_pkg
// Frame predictor for the HID keyboard/mouse encoder: mirrors the keyboard,
// button and address state and queues the bytes each event should produce.
// ----------------------------------------------------------------------------

package hidkm_frame_check_pkg;

   import hidkm_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_beat_type;

   class frame_tracker;

      logic [7:0]  address;
      logic [7:0]  modifiers;
      logic [7:0]  slot_code [KEY_SLOTS];
      logic        slot_held [KEY_SLOTS];
      logic [2:0]  buttons;
      frame_beat_type expected_beats [$];
      int unsigned errors;

      function new();
         address   = 8'h00;
         modifiers = 8'h00;
         buttons   = 3'b000;
         errors    = 0;
         foreach (slot_code[i]) begin
            slot_code[i] = 8'h00;
            slot_held[i] = 1'b0;
         end
      endfunction

      function void set_address(input logic [7:0] value);
         address = value;
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction

      // One line per mismatch, capped so a broken run stays readable
      task report(input string what);
         if (errors < 40)
            $display("ERROR @%0t: %s", $realtime, what);
         errors++;
      endtask

      function logic [7:0] send_delta(input logic [7:0] d);
         return (d == DELTA_MIN) ? 8'h00 : d;
      endfunction

      task push_frame(input logic [7:0] cmd, input logic [7:0] payload [$]);
         logic [7:0] bytes [$];
         logic [7:0] sum;
         bytes.push_back(HEAD0);
         bytes.push_back(HEAD1);
         bytes.push_back(address);
         bytes.push_back(cmd);
         bytes.push_back(8'(payload.size()));
         foreach (payload[i]) bytes.push_back(payload[i]);
         sum = 8'h00;
         foreach (bytes[i]) begin
            sum += bytes[i];
            expected_beats.push_back('{bytes[i], 1'b0});
         end
         expected_beats.push_back('{sum, 1'b1});
      endtask

      task mouse_frame(input logic [7:0] dx, input logic [7:0] dy, input logic [7:0] wh);
         logic [7:0] payload [$];
         payload.push_back(MOUSE_ID);
         payload.push_back({5'b00000, buttons});
         payload.push_back(dx);
         payload.push_back(dy);
         payload.push_back(wh);
         push_frame(CMD_MOUSE, payload);
      endtask

      task take_event(input logic [2:0] op, input logic [7:0] code, input logic [7:0] btn,
                      input logic [7:0] dx, input logic [7:0] dy, input logic [7:0] wheel);
         logic [7:0] payload [$];
         logic       held;
         int         slot;
         case (op)
            OP_KEY_PRESS, OP_KEY_RELEASE: begin
               slot = -1;
               held = 1'b0;
               if (code[7:3] == MOD_PREFIX) begin
                  modifiers[code[2:0]] = (op == OP_KEY_PRESS);
               end else if (op == OP_KEY_PRESS) begin
                  // repeated press is a no-op; no free slot drops the key
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (slot_held[i] && slot_code[i] == code) held = 1'b1;
                     if (!slot_held[i] && slot < 0) slot = i;
                  end
                  if (!held && slot >= 0) begin
                     slot_held[slot] = 1'b1;
                     slot_code[slot] = code;
                  end
               end else begin
                  // release matches the stored code, held or not
                  for (int i = 0; i < KEY_SLOTS; i++)
                     if (slot_code[i] == code && slot < 0) slot = i;
                  if (slot >= 0) begin
                     slot_held[slot] = 1'b0;
                     slot_code[slot] = 8'h00;
                  end
               end
               payload.push_back(modifiers);
               payload.push_back(8'h00);
               for (int i = 0; i < REPORT_SLOTS; i++)
                  payload.push_back((i < KEY_SLOTS && slot_held[i]) ? slot_code[i] : 8'h00);
               push_frame(CMD_KEYBOARD, payload);
            end
            OP_BTN_PRESS, OP_BTN_RELEASE: begin
               if (btn < NUM_BUTTONS) buttons[btn[1:0]] = (op == OP_BTN_PRESS);
               mouse_frame(8'h00, 8'h00, 8'h00);
            end
            OP_MOVE:  mouse_frame(send_delta(dx), send_delta(dy), 8'h00);
            OP_WHEEL: mouse_frame(8'h00, 8'h00, send_delta(wheel));
            default: ;   // spare op codes: no state change, no frame
         endcase
      endtask

      task check_byte(input logic [7:0] value, input logic last);
         frame_beat_type want;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected byte %02h (last %0b)", value, last));
            return;
         end
         want = expected_beats.pop_front();
         if (value !== want.value)
            report($sformatf("frame_byte %02h, want %02h", value, want.value));
         if (last !== want.last)
            report($sformatf("frame_last %0b, want %0b (byte %02h)", last, want.last, value));
      endtask

   endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HID keyboard/mouse frame encoder. Drives key,
// button, move, wheel and spare events plus device address writes, predicts every
// frame byte and compares each output beat against it in order.
// ----------------------------------------------------------------------------

module tb_top;

   import hidkm_pkg::*;
   import hidkm_frame_check_pkg::*;

   localparam int DRAIN_CYCLES = 16;     // longest frame plus output register
   localparam int STALL_LIMIT  = 2000;   // cycles with no beat on either side
   localparam int PHASE_EVENTS = 46;     // framed events per address setting
   localparam int NUM_PHASES   = 5;

   // Spare op codes, taken by the block and dropped without a frame
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] REG_DEVICE_ADDRESS = {CSR_IDX_DEVICE_ADDRESS, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   hidkm_req_if req_bus ();
   hidkm_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_tracker frames;

   logic        steady = 1'b0;       // when set, neither side idles
   int unsigned rx_hold = 0;
   int unsigned idle_cycles = 0;

   always #4 clock = ~clock;

   hid_keyboard_mouse_frame_encoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Idle lengths: mostly from the short range, now and then a long one
   // ------------------------------------------------------------------
   function automatic int unsigned idle_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   function automatic int unsigned sender_gap();
      return ($urandom_range(0, 99) < 60) ? 0 : idle_len();
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random stalls on the frame byte channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold       <= rx_hold - 1;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
         rsp_bus.ready <= 1'b0;
         rx_hold       <= idle_len() - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: an accepted event queues its frame, a byte beat is checked
   // against the oldest queued byte. Events go first: the block may take
   // a new event while the last byte of the previous frame is still out.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            frames.take_event(req_bus.op, req_bus.key_code, req_bus.mouse_button,
                              req_bus.delta_x, req_bus.delta_y, req_bus.wheel_delta);
         if (rsp_bus.valid && rsp_bus.ready)
            frames.check_byte(rsp_bus.frame_byte, rsp_bus.frame_last);
      end
   end

   // Watchdog: counts cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // One event beat; returns at the edge where it is taken
   task automatic post_event(input logic [2:0] op, input logic [7:0] code,
                             input logic [7:0] btn, input logic [7:0] dx,
                             input logic [7:0] dy, input logic [7:0] wheel);
      int unsigned gap;
      gap = steady ? 0 : sender_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.key_code     <= code;
      req_bus.mouse_button <= btn;
      req_bus.delta_x      <= dx;
      req_bus.delta_y      <= dy;
      req_bus.wheel_delta  <= wheel;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic key_event(input logic [2:0] op, input logic [7:0] code);
      post_event(op, code, rnd8(), rnd8(), rnd8(), rnd8());
   endtask

   task automatic mouse_event(input logic [2:0] op, input logic [7:0] btn,
                              input logic [7:0] dx, input logic [7:0] dy,
                              input logic [7:0] wheel);
      post_event(op, rnd8(), btn, dx, dy, wheel);
   endtask

   // Mostly well-formed traffic: key codes from a small pool so slots fill,
   // repeat and free up; some fully random codes and stray buttons as noise.
   task automatic post_random_event(output bit framed);
      int unsigned pick;
      logic [2:0]  op;
      logic [7:0]  code;
      logic [7:0]  btn;
      logic [7:0]  dx;
      logic [7:0]  dy;
      logic [7:0]  wheel;
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_KEY_PRESS;
      else if (pick < 55) op = OP_KEY_RELEASE;
      else if (pick < 65) op = OP_BTN_PRESS;
      else if (pick < 73) op = OP_BTN_RELEASE;
      else if (pick < 84) op = OP_MOVE;
      else if (pick < 95) op = OP_WHEEL;
      else                op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
      pick = $urandom_range(0, 99);
      if (pick < 25)      code = {MOD_PREFIX, 3'($urandom_range(0, 7))};
      else if (pick < 75) code = 8'h04 + 8'($urandom_range(0, 9));
      else                code = rnd8();
      btn   = ($urandom_range(0, 4) == 0) ? rnd8() : 8'($urandom_range(0, NUM_BUTTONS - 1));
      dx    = ($urandom_range(0, 9) == 0) ? DELTA_MIN : rnd8();
      dy    = ($urandom_range(0, 9) == 0) ? DELTA_MIN : rnd8();
      wheel = ($urandom_range(0, 9) == 0) ? DELTA_MIN : rnd8();
      framed = (op != OP_SPARE_6) && (op != OP_SPARE_7);
      post_event(op, code, btn, dx, dy, wheel);
   endtask

   // Hold off the sender until every queued byte is out, then let the
   // block settle; spare ops leave nothing queued but may still be in flight.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (frames.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, then access until pready
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] where,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= where;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (where == REG_DEVICE_ADDRESS) frames.set_address(value[7:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [7:0] phase_addr;
      int         count;
      bit         framed;

      frames = new();
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_KEY_PRESS;
      req_bus.key_code     <= 8'h00;
      req_bus.mouse_button <= 8'h00;
      req_bus.delta_x      <= 8'h00;
      req_bus.delta_y      <= 8'h00;
      req_bus.wheel_delta  <= 8'h00;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, address left at its reset value.
      // Modifier extremes, then fill all six slots (code 0 included).
      key_event(OP_KEY_PRESS, 8'hE0);
      key_event(OP_KEY_PRESS, 8'hE7);
      key_event(OP_KEY_PRESS, 8'h04);
      key_event(OP_KEY_PRESS, 8'h04);     // repeated press
      key_event(OP_KEY_PRESS, 8'h00);
      key_event(OP_KEY_PRESS, 8'hFF);
      key_event(OP_KEY_PRESS, 8'hDF);     // just below the modifier range
      key_event(OP_KEY_PRESS, 8'hE8);     // just above it
      key_event(OP_KEY_PRESS, 8'h1E);
      key_event(OP_KEY_PRESS, 8'h2C);     // slots full, dropped
      key_event(OP_KEY_RELEASE, 8'h00);
      key_event(OP_KEY_RELEASE, 8'h99);   // no slot holds it
      key_event(OP_KEY_RELEASE, 8'hE0);
      key_event(OP_KEY_PRESS, 8'h2C);     // takes the freed slot

      // Buttons, including indexes out of range
      mouse_event(OP_BTN_PRESS, 8'd0, rnd8(), rnd8(), rnd8());
      mouse_event(OP_BTN_PRESS, 8'd2, rnd8(), rnd8(), rnd8());
      mouse_event(OP_BTN_PRESS, 8'd3, rnd8(), rnd8(), rnd8());
      mouse_event(OP_BTN_RELEASE, 8'd0, rnd8(), rnd8(), rnd8());
      mouse_event(OP_BTN_PRESS, 8'hFF, rnd8(), rnd8(), rnd8());

      // Delta extremes; -128 must go out as zero
      mouse_event(OP_MOVE, rnd8(), DELTA_MIN, 8'h7F, rnd8());
      mouse_event(OP_MOVE, rnd8(), 8'h7F, DELTA_MIN, rnd8());
      mouse_event(OP_MOVE, rnd8(), 8'h01, 8'hFF, rnd8());
      mouse_event(OP_WHEEL, rnd8(), rnd8(), rnd8(), DELTA_MIN);
      mouse_event(OP_WHEEL, rnd8(), rnd8(), rnd8(), 8'h7F);

      // Spare ops produce nothing
      post_event(OP_SPARE_6, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
      post_event(OP_SPARE_7, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());

      // Random part: one device address per phase, extremes first.
      // Each phase starts with the sender held off until the block drains.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       phase_addr = 8'hFF;
            1:       phase_addr = 8'h00;
            3:       phase_addr = 8'h80;
            default: phase_addr = rnd8();
         endcase
         wait_idle();
         write_csr(REG_DEVICE_ADDRESS, {24'h000000, phase_addr});
         steady <= (phase == 2);    // one phase runs back to back
         count = 0;
         while (count < PHASE_EVENTS) begin
            post_random_event(framed);
            if (framed) count++;
         end
      end

      wait_idle();
      if (frames.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### hid_keyboard_mouse_frame_encoder_core.f
src/hidkm_pkg.sv
src/hidkm_if.sv
src/hid_keyboard_mouse_frame_encoder_core.sv
tb/sv/hidkm_frame_check_pkg.sv
tb/sv/tb_top.sv
